FILE: rtl/nnir_pkg.sv
// Shared types and constants for the nearest-neighbor resampler.
// No dependencies; imported by every module of the block.
package nnir_pkg;

    localparam int MAX_DIM_DEF = 256;

    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int CHAN_W  = 3;
    localparam int PIX_W   = 32;
    localparam int IDX_W   = 3;

    localparam int QUO_W      = DIM_W;
    localparam int DVD_W      = COORD_W + DIM_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_CYCLES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam int QUEUE_DEPTH = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_CHANNELS   = 3'd4;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] dw;
        logic [DIM_W-1:0] dh;
        logic             alpha_en;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pixel;
        logic [DVD_W-1:0]   num_x;
        logic [DVD_W-1:0]   num_y;
    } entry_t;

    typedef struct packed {
        logic             status;
        logic [PIX_W-1:0] pixel;
    } res_t;

endpackage

FILE: rtl/nnir_fifo.sv
// Small register queue with push/full and pop/empty sides, fall-through head.
// Depends on nnir_pkg for the default depth.
module nnir_fifo
    import nnir_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] data_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/nnir_front.sv
// Front end: range checks each request and forms the scale products.
// Depends on nnir_pkg.
module nnir_front
    import nnir_pkg::*;
(
    input  cfg_t               cfg,
    input  logic               command,
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    output entry_t             entry
);

    logic wr_err, rd_err;

    assign wr_err = ({1'b0, x} >= cfg.sw) || ({1'b0, y} >= cfg.sh);
    assign rd_err = ({1'b0, x} >= cfg.dw) || ({1'b0, y} >= cfg.dh);

    always_comb
    begin
        entry.x     = x;
        entry.y     = y;
        entry.pixel = {(cfg.alpha_en ? alpha : 8'd0), blue, green, red};
        entry.num_x = DVD_W'(x) * DVD_W'(cfg.sw);
        entry.num_y = DVD_W'(y) * DVD_W'(cfg.sh);
        case (command)
            CMD_WRITE: entry.kind = wr_err ? KIND_ERROR : KIND_WRITE;
            CMD_READ:  entry.kind = rd_err ? KIND_ERROR : KIND_READ;
            default:   entry.kind = KIND_ERROR;
        endcase
    end

endmodule

FILE: rtl/nnir_div.sv
// Iterative restoring divider, DIV_STEPS quotient bits per cycle.
// Dividend is known to give a quotient below 2**QUO_W. Depends on nnir_pkg.
module nnir_div
    import nnir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [QUO_W-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]     low_reg, low_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    assign done     = (cnt_reg == '0);
    assign quotient = low_reg;

    always_comb
    begin
        logic [QUO_W:0]   t;
        logic [QUO_W-1:0] r;
        logic [QUO_W-1:0] l;
        r = rem_reg;
        l = low_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            t = {r, l[QUO_W-1]};
            if (t >= {1'b0, divisor})
            begin
                r = QUO_W'(t - {1'b0, divisor});
                l = {l[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r = t[QUO_W-1:0];
                l = {l[QUO_W-2:0], 1'b0};
            end
        end
        rem_next = rem_reg;
        low_next = low_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = QUO_W'(dividend[DVD_W-1:QUO_W]);
            low_next = dividend[QUO_W-1:0];
            cnt_next = DIV_CNT_W'(DIV_CYCLES);
        end
        else if (!done)
        begin
            rem_next = r;
            low_next = l;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

endmodule

FILE: rtl/nnir_back.sv
// Back end: sequences queued requests against the pixel store.
// Depends on nnir_pkg and nnir_div.
module nnir_back
    import nnir_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   cmd_empty,
    input  entry_t cmd_head,
    output logic   cmd_pop,
    input  logic   res_full,
    output logic   res_push,
    output res_t   res_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] ROW_MUL = ADDR_W'(MAX_DIM);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [PIX_W-1:0] mem [0:DEPTH-1];
    logic [PIX_W-1:0] rd_data_reg;
    logic             mem_we, mem_re, div_start;
    logic             done_x, done_y;
    logic [QUO_W-1:0] qx, qy, sx, sy;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    nnir_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd_head.num_x),
        .divisor  (cfg.dw),
        .done     (done_x),
        .quotient (qx)
    );

    nnir_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd_head.num_y),
        .divisor  (cfg.dh),
        .done     (done_y),
        .quotient (qy)
    );

    assign sx = (qx > cfg.sw - 1'b1) ? cfg.sw - 1'b1 : qx;
    assign sy = (qy > cfg.sh - 1'b1) ? cfg.sh - 1'b1 : qy;

    assign wr_addr = ADDR_W'(ADDR_W'(cmd_head.y) * ROW_MUL) + ADDR_W'(cmd_head.x);
    assign rd_addr = ADDR_W'(ADDR_W'(sy) * ROW_MUL) + ADDR_W'(sx);

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res_data   = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    case (cmd_head.kind)
                        KIND_WRITE:
                        begin
                            cmd_pop = 1'b1;
                            mem_we  = 1'b1;
                        end
                        KIND_READ:
                        begin
                            cmd_pop    = 1'b1;
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        KIND_ERROR:
                        begin
                            if (!res_full)
                            begin
                                cmd_pop         = 1'b1;
                                res_push        = 1'b1;
                                res_data.status = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (done_x && done_y)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    res_data.pixel = {(cfg.alpha_en ? rd_data_reg[31:24] : 8'd0),
                                      rd_data_reg[23:0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cmd_head.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/nearest_neighbor_image_resampler_unit.sv
// Top level of the nearest-neighbor resampler: config registers and queues.
// Depends on nnir_pkg, nnir_front, nnir_fifo and nnir_back.
//
// Usage:
//   Requests enter through push/full: a pixel write (command 0) stores
//   red/green/blue/alpha at source (x, y); a read (command 1) maps the
//   destination (x, y) to the nearest source pixel and returns it.
//   Results leave through empty/pop; the oldest result sits on the output
//   ports while empty is low. Out-of-range requests return status 1 and
//   zero pixel bytes; a good write returns nothing.
//   Config writes use cfg_valid/cfg_ready (always ready) with cfg_index
//   selecting src_width, src_height, dst_width, dst_height, channels;
//   write them only while no request is in flight.
//   Throughput: writes retire one per cycle, and rejected requests one per
//   cycle while the result queue has room. A read holds the back end through
//   pop, the two coordinate dividers at 3 quotient bits per cycle, store read
//   and result push, and the push waits while the result queue is full.
//   Reset empties both queues and loads 256x256 dims and 4 channels; the
//   pixel store is not cleared. With pop held low the result queue fills, the
//   back end stalls at a read or rejection, the request queue fills, full rises.
module nearest_neighbor_image_resampler_unit
    import nnir_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [COORD_W-1:0] x,
    input  logic [COORD_W-1:0] y,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic [7:0]         out_alpha,
    output logic               status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    localparam logic [DIM_W-1:0] DIM_MAX = (MAX_DIM > 511) ? 9'd511 : DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]  src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [CHAN_W-1:0] channels_reg;
    cfg_t              cfg;
    entry_t            front_entry;
    entry_t            cmd_head;
    logic              cmd_empty, cmd_pop;
    logic              res_full, res_push;
    res_t              res_in, res_out;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        if (v == '0)
            return DIM_W'(1);
        else if (v > lim)
            return lim;
        else
            return v;
    endfunction

    assign cfg_ready    = 1'b1;
    assign cfg.sw       = eff_dim(src_width_reg, DIM_MAX);
    assign cfg.sh       = eff_dim(src_height_reg, DIM_MAX);
    assign cfg.dw       = eff_dim(dst_width_reg, DIM_MAX);
    assign cfg.dh       = eff_dim(dst_height_reg, DIM_MAX);
    assign cfg.alpha_en = (channels_reg == CHAN_W'(4));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= DIM_W'(256);
            src_height_reg <= DIM_W'(256);
            dst_width_reg  <= DIM_W'(256);
            dst_height_reg <= DIM_W'(256);
            channels_reg   <= CHAN_W'(4);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                REG_CHANNELS:   channels_reg   <= cfg_data[CHAN_W-1:0];
                default:        ;
            endcase
        end
    end

    nnir_front u_front (
        .cfg     (cfg),
        .command (command),
        .x       (x),
        .y       (y),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .alpha   (alpha),
        .entry   (front_entry)
    );

    nnir_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (front_entry),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd_head)
    );

    nnir_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    nnir_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (res_out)
    );

    assign out_red   = res_out.pixel[7:0];
    assign out_green = res_out.pixel[15:8];
    assign out_blue  = res_out.pixel[23:16];
    assign out_alpha = res_out.pixel[31:24];
    assign status    = res_out.status;

endmodule

FILE: tb/sv/tb_nearest_neighbor_image_resampler_unit.sv
// Self-checking testbench for nearest_neighbor_image_resampler_unit: directed and random
// pixel write/read requests under several resampling settings and handshake idling.
// Depends on nnir_pkg and the RTL of the block; a scoreboard class predicts each result.
module tb_nearest_neighbor_image_resampler_unit;
    import nnir_pkg::*;

    localparam int STORE_DIM      = MAX_DIM_DEF;
    localparam logic [DIM_W-1:0] CHAN_RGBA = DIM_W'(4);
    localparam logic [DIM_W-1:0] CHAN_RGB  = DIM_W'(3);
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 130;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
    } request_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       status;
    } pixel_result_t;

    class resample_scoreboard;
        int unsigned   sw_eff;
        int unsigned   sh_eff;
        int unsigned   dw_eff;
        int unsigned   dh_eff;
        bit            alpha_on;
        bit [31:0]     pixel_mem [STORE_DIM*STORE_DIM];
        bit            written [STORE_DIM*STORE_DIM];
        pixel_result_t expected_q [$];
        int            errors;

        function new();
            sw_eff   = STORE_DIM;
            sh_eff   = STORE_DIM;
            dw_eff   = STORE_DIM;
            dh_eff   = STORE_DIM;
            alpha_on = 1'b1;
            errors   = 0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > STORE_DIM)
                return STORE_DIM;
            return v;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                REG_SRC_WIDTH:  sw_eff = clamp_dim(data);
                REG_SRC_HEIGHT: sh_eff = clamp_dim(data);
                REG_DST_WIDTH:  dw_eff = clamp_dim(data);
                REG_DST_HEIGHT: dh_eff = clamp_dim(data);
                REG_CHANNELS:   alpha_on = (data[CHAN_W-1:0] == CHAN_W'(CHAN_RGBA));
                default: ;
            endcase
        endfunction

        function bit dst_inside(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            return (px < dw_eff) && (py < dh_eff);
        endfunction

        function int unsigned source_addr(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            int unsigned sx;
            int unsigned sy;
            sx = (int'(px) * sw_eff) / dw_eff;
            sy = (int'(py) * sh_eff) / dh_eff;
            if (sx > sw_eff - 1)
                sx = sw_eff - 1;
            if (sy > sh_eff - 1)
                sy = sh_eff - 1;
            return sy * STORE_DIM + sx;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(request_t r);
            pixel_result_t e;
            int unsigned   a;
            e = '0;
            if (r.command == CMD_WRITE) begin
                if (r.x >= sw_eff || r.y >= sh_eff) begin
                    e.status = 1'b1;
                    expected_q.push_back(e);
                end
                else begin
                    a = int'(r.y) * STORE_DIM + int'(r.x);
                    pixel_mem[a] = {(alpha_on ? r.alpha : 8'h00), r.blue, r.green, r.red};
                    written[a]   = 1'b1;
                end
            end
            else if (!dst_inside(r.x, r.y)) begin
                e.status = 1'b1;
                expected_q.push_back(e);
            end
            else begin
                a       = source_addr(r.x, r.y);
                e.red   = pixel_mem[a][7:0];
                e.green = pixel_mem[a][15:8];
                e.blue  = pixel_mem[a][23:16];
                e.alpha = alpha_on ? pixel_mem[a][31:24] : 8'h00;
                expected_q.push_back(e);
            end
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: r=%h g=%h b=%h a=%h st=%b",
                             got.red, got.green, got.blue, got.alpha, got.status);
                return;
            end
            e = expected_q.pop_front();
            if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
                got.alpha !== e.alpha || got.status !== e.status) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: exp r=%h g=%h b=%h a=%h st=%b, got r=%h g=%h b=%h a=%h st=%b",
                             e.red, e.green, e.blue, e.alpha, e.status,
                             got.red, got.green, got.blue, got.alpha, got.status);
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               push      = 1'b0;
    logic               full;
    logic               command   = CMD_WRITE;
    logic [COORD_W-1:0] x         = '0;
    logic [COORD_W-1:0] y         = '0;
    logic [7:0]         red       = '0;
    logic [7:0]         green     = '0;
    logic [7:0]         blue      = '0;
    logic [7:0]         alpha     = '0;
    logic               empty;
    logic               pop       = 1'b0;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic               status;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]   cfg_data  = '0;

    resample_scoreboard sb;
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;
    int                 quiet_cycles  = 0;

    nearest_neighbor_image_resampler_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .x         (x),
        .y         (y),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .empty     (empty),
        .pop       (pop),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check on accept, then pick next pop
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_result({out_red, out_green, out_blue, out_alpha, status});
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic request_t make_req(logic cmd, int px, int py, logic [31:0] pix);
        request_t r;
        r.command = cmd;
        r.x       = COORD_W'(px);
        r.y       = COORD_W'(py);
        {r.alpha, r.blue, r.green, r.red} = pix;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return DIM_W'($urandom_range(16, 1));
        if (r < 65)
            return DIM_W'($urandom_range(256, 17));
        if (r < 75)
            return DIM_W'(STORE_DIM);
        if (r < 82)
            return 1;
        if (r < 88)
            return 0;
        if (r < 94)
            return DIM_W'($urandom_range(511, 257));
        return 511;
    endfunction

    function automatic logic [DIM_W-1:0] pick_channels();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return CHAN_RGBA;
        if (r < 85)
            return CHAN_RGB;
        return DIM_W'($urandom_range(7, 0));
    endfunction

    // mostly in-range writes and reads, the rest anywhere in the field range
    function automatic request_t random_request();
        request_t r;
        int       k;
        r = make_req(CMD_WRITE, 0, 0, $urandom);
        k = $urandom_range(99);
        if (k < 45) begin
            r.x = COORD_W'($urandom_range(sb.sw_eff - 1, 0));
            r.y = COORD_W'($urandom_range(sb.sh_eff - 1, 0));
        end
        else if (k < 85) begin
            r.command = CMD_READ;
            r.x       = COORD_W'($urandom_range(sb.dw_eff - 1, 0));
            r.y       = COORD_W'($urandom_range(sb.dh_eff - 1, 0));
        end
        else begin
            r.command = 1'($urandom_range(1, 0));
            r.x       = COORD_W'($urandom_range(255, 0));
            r.y       = COORD_W'($urandom_range(255, 0));
        end
        return r;
    endfunction

    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        command <= r.command;
        x       <= r.x;
        y       <= r.y;
        red     <= r.red;
        green   <= r.green;
        blue    <= r.blue;
        alpha   <= r.alpha;
        do
            @(posedge clk);
        while (full);
        sb.note_request(r);
    endtask

    // a read must never land on a store entry nobody wrote: fill it first
    task automatic issue(request_t r);
        request_t    fill;
        int unsigned a;
        if (r.command == CMD_READ && sb.dst_inside(r.x, r.y)) begin
            a = sb.source_addr(r.x, r.y);
            if (!sb.written[a]) begin
                fill = make_req(CMD_WRITE, a % STORE_DIM, a / STORE_DIM, $urandom);
                send_request(fill);
            end
        end
        send_request(r);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setting(logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                                 logic [DIM_W-1:0] dw, logic [DIM_W-1:0] dh,
                                 logic [DIM_W-1:0] ch);
        cfg_write(REG_SRC_WIDTH, sw);
        cfg_write(REG_SRC_HEIGHT, sh);
        cfg_write(REG_DST_WIDTH, dw);
        cfg_write(REG_DST_HEIGHT, dh);
        cfg_write(REG_CHANNELS, ch);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(idle_mode_e mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 86; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 86; end
            IDLE_BOTH:     begin send_idle_pct = 18; stall_pct = 18; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(IDLE_NONE);

        // reset setting: identity mapping, corners, RGBA
        issue(make_req(CMD_WRITE, 0, 0, 32'hFFFF_FFFF));
        issue(make_req(CMD_WRITE, 255, 255, 32'h0000_0000));
        issue(make_req(CMD_WRITE, 255, 0, 32'h3CC3_5AA5));
        issue(make_req(CMD_WRITE, 0, 255, 32'h7856_3412));
        issue(make_req(CMD_READ, 0, 0, 32'h0));
        issue(make_req(CMD_READ, 255, 255, 32'hFFFF_FFFF));
        issue(make_req(CMD_READ, 255, 0, 32'h0));
        issue(make_req(CMD_READ, 0, 255, 32'h0));
        drain_results();

        // zero width acts as one, oversize height as full; RGB drops alpha
        apply_setting(0, 511, 5, 256, CHAN_RGB);
        issue(make_req(CMD_WRITE, 1, 0, 32'hAAAA_AAAA));
        issue(make_req(CMD_WRITE, 0, 255, 32'hFF11_2233));
        issue(make_req(CMD_READ, 4, 255, 32'h0));
        issue(make_req(CMD_READ, 5, 0, 32'h0));
        issue(make_req(CMD_READ, 0, 255, 32'h0));
        drain_results();

        // odd channel code counts as RGB; one-pixel destination
        apply_setting(256, 256, 1, 1, 7);
        issue(make_req(CMD_READ, 0, 0, 32'h0));
        issue(make_req(CMD_READ, 0, 1, 32'h0));
        issue(make_req(CMD_READ, 1, 0, 32'h0));
        issue(make_req(CMD_WRITE, 255, 255, 32'h8001_7E55));
        drain_results();

        // downscale with flooring
        apply_setting(200, 100, 3, 7, CHAN_RGBA);
        issue(make_req(CMD_READ, 2, 6, 32'h0));
        issue(make_req(CMD_WRITE, 200, 50, 32'h1234_5678));
        issue(make_req(CMD_WRITE, 199, 99, 32'hC0DE_F00D));
        issue(make_req(CMD_READ, 255, 255, 32'h0));
        issue(make_req(CMD_READ, 1, 3, 32'h0));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            apply_setting(pick_dim(), pick_dim(), pick_dim(), pick_dim(), pick_channels());
            set_idling(idle_mode_e'(p % 4));
            repeat (PHASE_REQUESTS) issue(random_request());
        end
        drain_results();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: nearest_neighbor_image_resampler_unit.f
rtl/nnir_pkg.sv
rtl/nnir_fifo.sv
rtl/nnir_front.sv
rtl/nnir_div.sv
rtl/nnir_back.sv
rtl/nearest_neighbor_image_resampler_unit.sv
tb/sv/tb_nearest_neighbor_image_resampler_unit.sv
